// File: hdl/pib_pkg.sv
// pib_pkg: shared constants and types for the periodic image buffer.
// No dependencies.

package pib_pkg;

  localparam int MAX_X_REACH_DEF = 1;
  localparam int MAX_RESULTS     = 26;
  localparam int CNT_W           = $clog2(MAX_RESULTS);
  localparam int IDX_W           = 24;
  localparam int LEN_W           = 31;
  localparam int CFG_AW          = 5;

  localparam logic [LEN_W-1:0] BOX_LEN_RST = LEN_W'(65536);
  localparam logic [LEN_W-1:0] BUF_W_RST   = '0;

  typedef enum logic [2:0] {
    REG_BOX_LEN_X    = 3'd0,
    REG_BOX_LEN_Y    = 3'd1,
    REG_BOX_LEN_Z    = 3'd2,
    REG_BUFFER_WIDTH = 3'd3,
    REG_TWO_D_MODE   = 3'd4
  } cfg_reg_t;

endpackage

// File: hdl/pib_in_if.sv
// pib_in_if: input channel carrying one particle position and index.
// Depends on pib_pkg.

interface pib_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [31:0]            pos_x;
  logic signed [31:0]            pos_y;
  logic signed [31:0]            pos_z;
  logic [pib_pkg::IDX_W-1:0]     particle_index;

  modport source (output valid, pos_x, pos_y, pos_z, particle_index, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, particle_index, output ready);
endinterface

// File: hdl/pib_out_if.sv
// pib_out_if: result channel carrying one periodic image.
// Depends on pib_pkg.

interface pib_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [31:0]            image_x;
  logic signed [31:0]            image_y;
  logic signed [31:0]            image_z;
  logic [pib_pkg::IDX_W-1:0]     source_index;
  logic                          last_image;

  modport source (output valid, image_x, image_y, image_z, source_index, last_image,
                  input ready);
  modport sink   (input valid, image_x, image_y, image_z, source_index, last_image,
                  output ready);
endinterface

// File: hdl/pib_emitter.sv
// pib_emitter: walks the candidate mask of one item, issuing one image per cycle unless out_item stalls.
// Depends on pib_pkg and pib_out_if.

module pib_emitter #(
  parameter int MAX_X_REACH = pib_pkg::MAX_X_REACH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           s3_valid,
  output logic                           s3_ready,
  input  logic [(2*MAX_X_REACH+1)*9-1:0] s3_vec,
  input  logic signed [31:0]             s3_xs [2*MAX_X_REACH+1],
  input  logic signed [31:0]             s3_ys [3],
  input  logic signed [31:0]             s3_zs [3],
  input  logic [pib_pkg::IDX_W-1:0]      s3_idx,
  pib_out_if.source                      out_item
);

  localparam int NX = 2 * MAX_X_REACH + 1;
  localparam int NC = NX * 9;
  localparam int XW = $clog2(NX);
  localparam int PW = $clog2(NC);

  logic                         em_v_r;
  logic [NC-1:0]                vec_r;
  logic [pib_pkg::CNT_W-1:0]    cnt_r;
  logic signed [31:0]           xs_r [NX];
  logic signed [31:0]           ys_r [3];
  logic signed [31:0]           zs_r [3];
  logic [pib_pkg::IDX_W-1:0]    idx_r;

  logic                         out_v_r;
  logic signed [31:0]           out_x_r;
  logic signed [31:0]           out_y_r;
  logic signed [31:0]           out_z_r;
  logic [pib_pkg::IDX_W-1:0]    out_idx_r;
  logic                         out_last_r;

  logic          found;
  logic [XW-1:0] sel_x;
  logic [1:0]    sel_y;
  logic [1:0]    sel_z;
  logic [PW-1:0] sel_p;
  logic [NC-1:0] rem;
  logic          last;
  logic          em_adv;
  logic          em_take;

  // lowest set candidate in loop order
  always_comb begin
    found = 1'b0;
    sel_x = '0;
    sel_y = '0;
    sel_z = '0;
    sel_p = '0;
    for (int gx = 0; gx < NX; gx++) begin
      for (int gy = 0; gy < 3; gy++) begin
        for (int gz = 0; gz < 3; gz++) begin
          if (!found && vec_r[gx*9+gy*3+gz]) begin
            found = 1'b1;
            sel_x = XW'(gx);
            sel_y = 2'(gy);
            sel_z = 2'(gz);
            sel_p = PW'(gx*9+gy*3+gz);
          end
        end
      end
    end
  end

  assign rem      = vec_r & ~(NC'(1) << sel_p);
  assign last     = (rem == '0) || (cnt_r == pib_pkg::CNT_W'(pib_pkg::MAX_RESULTS - 1));
  assign em_adv   = em_v_r && (!out_v_r || out_item.ready);
  assign s3_ready = !em_v_r || (em_adv && last);
  assign em_take  = s3_valid && s3_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_v_r <= 1'b0;
    end else if (em_take) begin
      em_v_r <= |s3_vec;
    end else if (em_adv && last) begin
      em_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (em_take) begin
      vec_r <= s3_vec;
      cnt_r <= '0;
      xs_r  <= s3_xs;
      ys_r  <= s3_ys;
      zs_r  <= s3_zs;
      idx_r <= s3_idx;
    end else if (em_adv) begin
      vec_r <= rem;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (em_adv) begin
      out_v_r <= 1'b1;
    end else if (out_item.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (em_adv) begin
      out_x_r    <= xs_r[sel_x];
      out_y_r    <= ys_r[sel_y];
      out_z_r    <= zs_r[sel_z];
      out_idx_r  <= idx_r;
      out_last_r <= last;
    end
  end

  assign out_item.valid        = out_v_r;
  assign out_item.image_x      = out_x_r;
  assign out_item.image_y      = out_y_r;
  assign out_item.image_z      = out_z_r;
  assign out_item.source_index = out_idx_r;
  assign out_item.last_image   = out_last_r;

endmodule

// File: hdl/periodic_image_buffer_top.sv
// periodic_image_buffer_top: periodic ghost images of one particle, APB config.
// Depends on pib_pkg, pib_in_if, pib_out_if and pib_emitter.
//
//   channel   direction  handshake            payload
//   in_item   in         valid/ready          pos_x, pos_y, pos_z, particle_index
//   out_item  out        valid/ready          image_x/y/z, source_index, last_image
//   config    in         APB psel/penable     box lengths, buffer width, 2D flag
//
// Three register stages (input, shifted coordinates, inside test with candidate mask)
// feed the emitter, which issues one image per cycle from its candidate mask while
// out_item does not stall. An item yields at most 26 images. The first image of an
// item passes the input, shifted-coordinate and mask stages, then the emitter's mask
// and output registers, before it is offered on out_item.
// Reset is synchronous, active low; stalls on out_item back up the stages in order.

module periodic_image_buffer_top #(
  parameter int MAX_X_REACH = pib_pkg::MAX_X_REACH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  pib_in_if.sink                     in_item,
  pib_out_if.source                  out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pib_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int NX = 2 * MAX_X_REACH + 1;
  localparam int NC = NX * 9;
  localparam int RW = $clog2(MAX_X_REACH + 1);
  localparam int CW = 33 + RW;
  localparam int LW = CW + 2;
  localparam int L  = pib_pkg::LEN_W;

  // configuration
  logic [L-1:0] lx_r, ly_r, lz_r, buf_r;
  logic         two_d_r;
  logic [32:0]  lim_x_r, lim_y_r, lim_z_r;
  logic [RW-1:0] reach_r, reach_nxt;
  logic         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r    <= pib_pkg::BOX_LEN_RST;
      ly_r    <= pib_pkg::BOX_LEN_RST;
      lz_r    <= pib_pkg::BOX_LEN_RST;
      buf_r   <= pib_pkg::BUF_W_RST;
      two_d_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        pib_pkg::REG_BOX_LEN_X:    lx_r    <= pwdata[L-1:0];
        pib_pkg::REG_BOX_LEN_Y:    ly_r    <= pwdata[L-1:0];
        pib_pkg::REG_BOX_LEN_Z:    lz_r    <= pwdata[L-1:0];
        pib_pkg::REG_BUFFER_WIDTH: buf_r   <= pwdata[L-1:0];
        pib_pkg::REG_TWO_D_MODE:   two_d_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      pib_pkg::REG_BOX_LEN_X:    prdata = 32'(lx_r);
      pib_pkg::REG_BOX_LEN_Y:    prdata = 32'(ly_r);
      pib_pkg::REG_BOX_LEN_Z:    prdata = 32'(lz_r);
      pib_pkg::REG_BUFFER_WIDTH: prdata = 32'(buf_r);
      pib_pkg::REG_TWO_D_MODE:   prdata = 32'(two_d_r);
      default:                   prdata = '0;
    endcase
  end

  // x reach: ceil(buf / lx) >= m exactly when buf > (m-1)*lx
  always_comb begin
    reach_nxt = '0;
    for (int m = 1; m <= MAX_X_REACH; m++) begin
      if (33'(buf_r) > 33'(lx_r) * 33'(m - 1)) begin
        reach_nxt = RW'(m);
      end
    end
  end

  always_ff @(posedge clk) begin
    reach_r <= reach_nxt;
    lim_x_r <= 33'(lx_r) + {1'b0, buf_r, 1'b0};
    lim_y_r <= 33'(ly_r) + {1'b0, buf_r, 1'b0};
    lim_z_r <= 33'(lz_r) + {1'b0, buf_r, 1'b0};
  end

  function automatic logic in_box(logic signed [CW-1:0] c, logic [32:0] lim);
    logic signed [LW-1:0] tw;
    logic signed [LW-1:0] ls;
    tw = LW'(c) + LW'(c);
    ls = LW'(lim);
    return (tw < ls) && (tw > -ls);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [CW-1:0] c);
    if (c[CW-1:31] == '0 || c[CW-1:31] == '1) begin
      return c[31:0];
    end
    return c[CW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  // pipeline control
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  logic em_ready;

  assign rdy3          = !v3_r || em_ready;
  assign rdy2          = !v2_r || rdy3;
  assign rdy1          = !v1_r || rdy2;
  assign in_item.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_item.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // stage 1: input register
  logic signed [31:0]        s1_px_r, s1_py_r, s1_pz_r;
  logic [pib_pkg::IDX_W-1:0] s1_idx_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_px_r  <= in_item.pos_x;
      s1_py_r  <= in_item.pos_y;
      s1_pz_r  <= in_item.pos_z;
      s1_idx_r <= in_item.particle_index;
    end
  end

  // stage 2: shifted coordinates
  logic signed [CW-1:0]      x_c_nxt [NX];
  logic signed [CW-1:0]      y_c_nxt [3];
  logic signed [CW-1:0]      z_c_nxt [3];
  logic signed [CW-1:0]      x_c_r   [NX];
  logic signed [CW-1:0]      y_c_r   [3];
  logic signed [CW-1:0]      z_c_r   [3];
  logic [pib_pkg::IDX_W-1:0] s2_idx_r;
  logic signed [CW-1:0]      lx_s, ly_s, lz_s;

  assign lx_s = CW'(lx_r);
  assign ly_s = CW'(ly_r);
  assign lz_s = CW'(lz_r);

  for (genvar g = 0; g < NX; g++) begin : g_xc
    localparam int OFF = g - MAX_X_REACH;
    assign x_c_nxt[g] = CW'(s1_px_r) + CW'(OFF) * lx_s;
  end

  for (genvar g = 0; g < 3; g++) begin : g_yzc
    localparam int OFF = g - 1;
    assign y_c_nxt[g] = CW'(s1_py_r) + CW'(OFF) * ly_s;
    assign z_c_nxt[g] = CW'(s1_pz_r) + CW'(OFF) * lz_s;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      x_c_r    <= x_c_nxt;
      y_c_r    <= y_c_nxt;
      z_c_r    <= z_c_nxt;
      s2_idx_r <= s1_idx_r;
    end
  end

  // stage 3: inside tests, saturation and candidate mask
  logic [NX-1:0]             xm;
  logic [2:0]                ym, zm;
  logic [NC-1:0]             vec_nxt, s3_vec_r;
  logic signed [31:0]        xs_nxt [NX];
  logic signed [31:0]        ys_nxt [3];
  logic signed [31:0]        zs_nxt [3];
  logic signed [31:0]        s3_xs_r [NX];
  logic signed [31:0]        s3_ys_r [3];
  logic signed [31:0]        s3_zs_r [3];
  logic [pib_pkg::IDX_W-1:0] s3_idx_r;

  for (genvar g = 0; g < NX; g++) begin : g_xm
    localparam int OFF  = g - MAX_X_REACH;
    localparam int AOFF = (OFF < 0) ? -OFF : OFF;
    assign xm[g]     = in_box(x_c_r[g], lim_x_r) && (RW'(AOFF) <= reach_r);
    assign xs_nxt[g] = sat32(x_c_r[g]);
  end

  for (genvar g = 0; g < 3; g++) begin : g_yzm
    assign ym[g]     = in_box(y_c_r[g], lim_y_r);
    assign zm[g]     = two_d_r ? (g == 1) : in_box(z_c_r[g], lim_z_r);
    assign ys_nxt[g] = sat32(y_c_r[g]);
    assign zs_nxt[g] = two_d_r ? 32'sd0 : sat32(z_c_r[g]);
  end

  for (genvar gx = 0; gx < NX; gx++) begin : g_vx
    for (genvar gy = 0; gy < 3; gy++) begin : g_vy
      for (genvar gz = 0; gz < 3; gz++) begin : g_vz
        localparam bit CENTRE = (gx == MAX_X_REACH) && (gy == 1) && (gz == 1);
        assign vec_nxt[gx*9+gy*3+gz] = !CENTRE && xm[gx] && ym[gy] && zm[gz];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_vec_r <= vec_nxt;
      s3_xs_r  <= xs_nxt;
      s3_ys_r  <= ys_nxt;
      s3_zs_r  <= zs_nxt;
      s3_idx_r <= s2_idx_r;
    end
  end

  pib_emitter #(
    .MAX_X_REACH (MAX_X_REACH)
  ) u_emitter (
    .clk      (clk),
    .rst_n    (rst_n),
    .s3_valid (v3_r),
    .s3_ready (em_ready),
    .s3_vec   (s3_vec_r),
    .s3_xs    (s3_xs_r),
    .s3_ys    (s3_ys_r),
    .s3_zs    (s3_zs_r),
    .s3_idx   (s3_idx_r),
    .out_item (out_item)
  );

endmodule

// File: dv/tb.sv
// tb: self-checking bench for periodic_image_buffer_top; predicts every periodic image of
// each particle and compares the result stream item by item.
// Depends on pib_pkg, pib_in_if, pib_out_if and the periodic_image_buffer_top RTL.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     REACH           = pib_pkg::MAX_X_REACH_DEF;
  localparam int     HOLD_OFF_CYCLES = 300;
  localparam int     SETTLE_CYCLES   = 12;
  localparam int     CYCLE_LIMIT     = 400000;
  localparam int     RANDOM_PHASES   = 7;
  localparam int     PHASE_ITEMS     = 31;
  localparam longint INT32_TOP       = 64'sd2147483647;
  localparam longint INT32_BOTTOM    = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0]        x;
    logic signed [31:0]        y;
    logic signed [31:0]        z;
    logic [pib_pkg::IDX_W-1:0] idx;
    logic                      last;
  } image_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [pib_pkg::CFG_AW-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  pib_in_if  in_item ();
  pib_out_if out_item ();

  periodic_image_buffer_top #(.MAX_X_REACH(REACH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // register copies
  logic [pib_pkg::LEN_W-1:0] box_x;
  logic [pib_pkg::LEN_W-1:0] box_y;
  logic [pib_pkg::LEN_W-1:0] box_z;
  logic [pib_pkg::LEN_W-1:0] margin;
  logic                      flat_mode;

  image_t images_pending[$];
  int     error_count;
  int     images_checked;
  int     particles_sent;
  int     cycle_count;
  int     burst_left;
  int     max_gap;
  int     stall_pct;
  bit     hold_off_req;

  function automatic logic [31:0] clamp32(longint c);
    if (c > INT32_TOP) return 32'h7FFF_FFFF;
    if (c < INT32_BOTTOM) return 32'h8000_0000;
    return c[31:0];
  endfunction

  function automatic bit is_inside(longint c, logic [pib_pkg::LEN_W-1:0] len);
    longint lim;
    longint m;
    lim = len;
    m   = margin;
    lim = lim + 2 * m;
    return (2 * c < lim) && (2 * c > -lim);
  endfunction

  function automatic longint shift_reach();
    longint lx;
    longint bw;
    longint r;
    lx = box_x;
    bw = margin;
    if (lx == 0) return (bw == 0) ? 0 : REACH;
    r = (bw + lx - 1) / lx;
    return (r > REACH) ? REACH : r;
  endfunction

  function automatic void compute_images(logic signed [31:0] px, logic signed [31:0] py,
                                         logic signed [31:0] pz,
                                         logic [pib_pkg::IDX_W-1:0] idx);
    longint reach, lx, ly, lz, ix, iy, iz;
    int     i, j, k, k_lo, k_hi, produced;
    image_t img;
    reach    = shift_reach();
    lx       = box_x;
    ly       = box_y;
    lz       = box_z;
    k_lo     = flat_mode ? 0 : -1;
    k_hi     = flat_mode ? 0 : 1;
    produced = 0;
    for (i = -int'(reach); i <= int'(reach); i++)
      for (j = -1; j <= 1; j++)
        for (k = k_lo; k <= k_hi; k++) begin
          if (i == 0 && j == 0 && k == 0) continue;
          ix = longint'(px) + i * lx;
          iy = longint'(py) + j * ly;
          iz = flat_mode ? 0 : longint'(pz) + k * lz;
          if (!is_inside(ix, box_x) || !is_inside(iy, box_y)) continue;
          if (!flat_mode && !is_inside(iz, box_z)) continue;
          if (produced >= pib_pkg::MAX_RESULTS) continue;
          img.x    = clamp32(ix);
          img.y    = clamp32(iy);
          img.z    = clamp32(iz);
          img.idx  = idx;
          img.last = 1'b0;
          images_pending.insert(images_pending.size(), img);
          produced++;
        end
    if (produced > 0) images_pending[images_pending.size()-1].last = 1'b1;
  endfunction

  task automatic cfg_write(pib_pkg::cfg_reg_t r, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    unique case (r)
      pib_pkg::REG_BOX_LEN_X:    box_x     = value[pib_pkg::LEN_W-1:0];
      pib_pkg::REG_BOX_LEN_Y:    box_y     = value[pib_pkg::LEN_W-1:0];
      pib_pkg::REG_BOX_LEN_Z:    box_z     = value[pib_pkg::LEN_W-1:0];
      pib_pkg::REG_BUFFER_WIDTH: margin    = value[pib_pkg::LEN_W-1:0];
      pib_pkg::REG_TWO_D_MODE:   flat_mode = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                         logic [31:0] bw, bit flat);
    cfg_write(pib_pkg::REG_BOX_LEN_X, lx);
    cfg_write(pib_pkg::REG_BOX_LEN_Y, ly);
    cfg_write(pib_pkg::REG_BOX_LEN_Z, lz);
    cfg_write(pib_pkg::REG_BUFFER_WIDTH, bw);
    cfg_write(pib_pkg::REG_TWO_D_MODE, {31'd0, flat});
  endtask

  task automatic send_particle(logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [31:0] pz, logic [pib_pkg::IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_item.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    compute_images(px, py, pz, idx);
    in_item.valid          <= 1'b1;
    in_item.pos_x          <= px;
    in_item.pos_y          <= py;
    in_item.pos_z          <= pz;
    in_item.particle_index <= idx;
    do @(posedge clk); while (!in_item.ready);
    particles_sent++;
  endtask

  // block goes idle: nothing owed, and any image-less item has cleared the stages
  task automatic settle();
    in_item.valid <= 1'b0;
    while (images_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] near_coord(logic [pib_pkg::LEN_W-1:0] len);
    longint          span, m, pick;
    longint unsigned raw, modulus;
    span    = len;
    m       = margin;
    span    = span / 2 + m + 1;
    modulus = 2 * span + 1;
    raw     = {$urandom, $urandom};
    pick    = raw % modulus;
    return clamp32(pick - span);
  endfunction

  task automatic send_random_particle(int full_pct);
    logic [31:0] px, py, pz;
    if ($urandom_range(99) < full_pct) begin
      px = $urandom;
      py = $urandom;
      pz = $urandom;
    end else begin
      px = near_coord(box_x);
      py = near_coord(box_y);
      pz = near_coord(box_z);
    end
    send_particle(px, py, pz, pib_pkg::IDX_W'($urandom));
  endtask

  task automatic test_default_box();
    settle();
    send_particle(32'sd0, 32'sd0, 32'sd0, '0);
    send_particle(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, '1);
    send_particle(32'sh0000_8000, 32'sh0000_4000, -32'sh0000_8000, 24'h5A5A5A);
  endtask

  task automatic test_buffered_3d();
    settle();
    set_box(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0001, 1'b0);
    send_particle(32'sd0, 32'sd0, 32'sd0, 24'h000001);
    send_particle(32'sh0000_4000, 32'sh0000_4000, 32'sh0000_4000, '1);
    send_particle(32'sh0001_8000, 32'sd0, -32'sh0001_8000, 24'h800000);
    send_particle(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, '0);
    settle();
    cfg_write(pib_pkg::REG_BUFFER_WIDTH, 32'h0000_8000);
    send_particle(32'sd0, 32'sd0, 32'sd0, 24'h123456);
    send_particle(32'sh0000_4000, -32'sh0000_4000, 32'sh0000_4000, 24'hABCDEF);
  endtask

  task automatic test_flat_mode();
    settle();
    set_box(32'h0001_0000, 32'h0002_0000, 32'h0000_0100, 32'h0000_8000, 1'b1);
    send_particle(32'sh0000_4000, 32'sh0000_4000, 32'sh7FFF_FFFF, 24'h000010);
    send_particle(32'sd0, 32'sd0, 32'sh8000_0000, 24'h000011);
    settle();
    cfg_write(pib_pkg::REG_BUFFER_WIDTH, 32'h0000_0000);
    send_particle(32'sd0, 32'sh0000_4000, 32'sh0001_0000, 24'h000012);
    send_particle(32'sd0, -32'sh0000_C000, 32'sd0, 24'h000013);
  endtask

  task automatic test_zero_x_length();
    settle();
    set_box(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 1'b0);
    send_particle(32'sd0, 32'sd0, 32'sd0, 24'h000020);
    settle();
    cfg_write(pib_pkg::REG_BUFFER_WIDTH, 32'h0001_0000);
    send_particle(32'sd0, 32'sh0000_4000, 32'sh0000_4000, 24'h000021);
    send_particle(32'sh0000_F000, 32'sd0, -32'sh0000_4000, 24'h000022);
  endtask

  task automatic test_saturated_images();
    settle();
    set_box(32'h4000_1000, 32'h4000_1000, 32'h4000_1000, 32'h7FFF_FFFF, 1'b0);
    send_particle(32'sh4000_0000, 32'sd0, 32'sd0, 24'h000030);
    send_particle(-32'sh4000_0000, -32'sh4000_0000, 32'sh4000_0000, 24'h000031);
    send_particle(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 24'h000032);
  endtask

  task automatic test_extreme_lengths();
    settle();
    set_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_particle(32'sd0, 32'sd0, 32'sd0, 24'h000040);
    send_particle(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 24'h000041);
    settle();
    set_box(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000, 1'b0);
    send_particle(32'sd1, 32'sd1, 32'sd1, 24'h000042);
    send_particle(32'sd0, 32'sd0, 32'sd0, 24'h000043);
  endtask

  task automatic test_random_particles();
    int          phase, n;
    logic [31:0] lx, ly, lz, bw;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      if (phase == RANDOM_PHASES - 1) begin
        lx = $urandom_range(32'h7FFF_FFFF, 1);
        ly = $urandom_range(32'h7FFF_FFFF, 1);
        lz = $urandom_range(32'h7FFF_FFFF, 1);
        bw = $urandom & 32'h7FFF_FFFF;
      end else begin
        lx = $urandom_range(32'h0010_0000, 32'h0000_1000);
        ly = $urandom_range(32'h0010_0000, 32'h0000_1000);
        lz = $urandom_range(32'h0010_0000, 32'h0000_1000);
        bw = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(lx + lx / 2, 0);
      end
      set_box(lx, ly, lz, bw, phase[0]);
      max_gap   = (phase == 0) ? 0 : $urandom_range(12, 1);
      stall_pct = (phase == 0) ? 0 : $urandom_range(70, 10);
      burst_left = 0;
      for (n = 0; n < PHASE_ITEMS; n++) send_random_particle(20);
    end
  endtask

  task automatic test_output_hold_off();
    int n;
    settle();
    set_box(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0001, 1'b0);
    max_gap      = 0;
    stall_pct    = 0;
    hold_off_req = 1'b1;
    for (n = 0; n < 20; n++) send_random_particle(0);
  endtask

  // result receiver: runs of ready/stall, plus a long hold-off on request
  initial begin : result_receiver
    int hold_cnt;
    int run_left;
    bit level;
    out_item.ready <= 1'b0;
    run_left = 0;
    level    = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_item.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_OFF_CYCLES; hold_cnt++) @(posedge clk);
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          level    = ($urandom_range(99) >= stall_pct);
          run_left = $urandom_range(6, 1);
        end
        run_left--;
        out_item.ready <= level;
      end
    end
  end

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : image_check
    image_t want;
    if (rst_n && out_item.valid && out_item.ready) begin
      if (images_pending.size() == 0) begin
        $error("unexpected image: x 0x%08h y 0x%08h z 0x%08h index 0x%06h",
               out_item.image_x, out_item.image_y, out_item.image_z, out_item.source_index);
        error_count++;
      end else begin
        want = images_pending.pop_front();
        compare_field("image_x", want.x, out_item.image_x);
        compare_field("image_y", want.y, out_item.image_y);
        compare_field("image_z", want.z, out_item.image_z);
        compare_field("source_index", 32'(want.idx), 32'(out_item.source_index));
        compare_field("last_image", 32'(want.last), 32'(out_item.last_image));
        images_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    error_count    = 0;
    images_checked = 0;
    particles_sent = 0;
    cycle_count    = 0;
    burst_left     = 0;
    max_gap        = 3;
    stall_pct      = 30;
    hold_off_req   = 1'b0;
    box_x          = pib_pkg::BOX_LEN_RST;
    box_y          = pib_pkg::BOX_LEN_RST;
    box_z          = pib_pkg::BOX_LEN_RST;
    margin         = pib_pkg::BUF_W_RST;
    flat_mode      = 1'b0;
    rst_n                  <= 1'b0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    in_item.valid          <= 1'b0;
    in_item.pos_x          <= '0;
    in_item.pos_y          <= '0;
    in_item.pos_z          <= '0;
    in_item.particle_index <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_box();
    test_buffered_3d();
    test_flat_mode();
    test_zero_x_length();
    test_saturated_images();
    test_extreme_lengths();
    test_random_particles();
    test_output_hold_off();
    settle();

    $display("Covered %0d particles and %0d images: default, buffered, 2D, zero x length,",
             particles_sent, images_checked);
    $display("saturating and extreme boxes, random boxes with gaps, stalls and a long hold-off");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/pib_pkg.sv
hdl/pib_in_if.sv
hdl/pib_out_if.sv
hdl/pib_emitter.sv
hdl/periodic_image_buffer_top.sv
dv/tb.sv
